// ===== design/lld_pkg.sv =====
// lld_pkg: widths, status codes and item structs for the line-line distance block
// no dependencies; imported by every module of the block
package lld_pkg;

   localparam int COORD_W  = 16;
   localparam int DIST_W   = 17;
   localparam int CSR_W    = 32;

   localparam int DP_W     = COORD_W + 1;
   localparam int PROD_W   = 2 * COORD_W;
   localparam int N_W      = PROD_W + 1;
   localparam int AP_W     = DP_W + COORD_W;
   localparam int A_W      = AP_W + 1;
   localparam int PJP_W    = DP_W + N_W;
   localparam int PJ_W     = PJP_W + 2;
   localparam int HALF_W   = PJ_W / 2;
   localparam int DET_W    = 2 * N_W + 2;
   localparam int A2_W     = 2 * A_W + 2;
   localparam int V2_W     = PROD_W + 2;
   localparam int NUM_W    = 2 * PJ_W;
   localparam int DEN_W    = DET_W;
   localparam int QW       = 2 * DIST_W;
   localparam int QS_W     = QW + 1;

   typedef enum logic [1:0] {
      STATUS_SKEW       = 2'd0,
      STATUS_PARALLEL   = 2'd1,
      STATUS_DEGENERATE = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] first_point_x;
      logic signed [COORD_W-1:0] first_point_y;
      logic signed [COORD_W-1:0] first_point_z;
      logic signed [COORD_W-1:0] first_dir_x;
      logic signed [COORD_W-1:0] first_dir_y;
      logic signed [COORD_W-1:0] first_dir_z;
      logic signed [COORD_W-1:0] second_point_x;
      logic signed [COORD_W-1:0] second_point_y;
      logic signed [COORD_W-1:0] second_point_z;
      logic signed [COORD_W-1:0] second_dir_x;
      logic signed [COORD_W-1:0] second_dir_y;
      logic signed [COORD_W-1:0] second_dir_z;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      status_type        status;
   } rsp_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      status_type       status;
   } div_in_type;

   typedef struct packed {
      logic [QW-1:0] q;
      status_type    status;
   } root_in_type;

endpackage

// ===== design/lld_geom.sv =====
// lld_geom: seven-stage vector front end, builds the ratio whose root is the distance
// depends on lld_pkg
module lld_geom (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [lld_pkg::CSR_W-1:0]   threshold,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  lld_pkg::req_type            in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output lld_pkg::div_in_type         out_data
);
   import lld_pkg::*;

   localparam int STAGES = 7;

   logic [STAGES:1] v_ff, v_in, en;

   logic signed [COORD_W-1:0] p1 [3];
   logic signed [COORD_W-1:0] v1 [3];
   logic signed [COORD_W-1:0] p2 [3];
   logic signed [COORD_W-1:0] v2 [3];

   logic signed [DP_W-1:0]    dp1_ff [3];
   logic signed [PROD_W-1:0]  pa1_ff [3];
   logic signed [PROD_W-1:0]  pb1_ff [3];
   logic signed [COORD_W-1:0] v1_1_ff [3];

   logic signed [N_W-1:0]     n2_ff [3];
   logic signed [DP_W-1:0]    dp2_ff [3];
   logic signed [AP_W-1:0]    aa2_ff [3];
   logic signed [AP_W-1:0]    ab2_ff [3];
   logic [PROD_W-1:0]         v1sq2_ff [3];
   logic                      zero2_ff;

   logic signed [A_W-1:0]     a3_ff [3];
   logic [2*N_W-1:0]          nsq3_ff [3];
   logic signed [PJP_W-1:0]   pj3_ff [3];
   logic [V2_W-1:0]           v1n3_ff;
   logic                      zero3_ff;

   logic [DET_W-1:0]          det4_ff;
   logic signed [PJ_W-1:0]    proj4_ff;
   logic [2*A_W-1:0]          asq4_ff [3];
   logic [V2_W-1:0]           v1n4_ff;
   logic                      zero4_ff;

   logic [PJ_W-1:0]           mag5_ff;
   logic                      skew5_ff;
   logic [A2_W-1:0]           a2_5_ff;
   logic [DET_W-1:0]          det5_ff;
   logic [V2_W-1:0]           v1n5_ff;
   logic                      zero5_ff;

   logic [2*HALF_W-1:0]       hh6_ff, hl6_ff, ll6_ff;
   status_type                st6_ff;
   logic [A2_W-1:0]           a2_6_ff;
   logic [DET_W-1:0]          det6_ff;
   logic [V2_W-1:0]           v1n6_ff;

   logic [NUM_W-1:0]          num7_ff;
   logic [DEN_W-1:0]          den7_ff;
   status_type                st7_ff;

   assign p1 = '{in_data.first_point_x, in_data.first_point_y, in_data.first_point_z};
   assign v1 = '{in_data.first_dir_x, in_data.first_dir_y, in_data.first_dir_z};
   assign p2 = '{in_data.second_point_x, in_data.second_point_y, in_data.second_point_z};
   assign v2 = '{in_data.second_dir_x, in_data.second_dir_y, in_data.second_dir_z};

   always_comb begin
      v_in = {v_ff[STAGES-1:1], in_valid};
      en[STAGES] = !v_ff[STAGES] || out_ready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign in_ready  = en[1];
   assign out_valid = v_ff[STAGES];
   assign out_data  = '{num: num7_ff, den: den7_ff, status: st7_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (v_ff & ~en) | (v_in & en);
      end
   end

   // point difference and cross product terms of the two directions
   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int i = 0; i < 3; i++) begin
            dp1_ff[i]  <= p2[i] - p1[i];
            v1_1_ff[i] <= v1[i];
         end
         pa1_ff[0] <= v1[1] * v2[2];
         pb1_ff[0] <= v1[2] * v2[1];
         pa1_ff[1] <= v1[2] * v2[0];
         pb1_ff[1] <= v1[0] * v2[2];
         pa1_ff[2] <= v1[0] * v2[1];
         pb1_ff[2] <= v1[1] * v2[0];
      end
   end

   // normal vector, dp x v1 terms, |v1|^2 terms
   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int i = 0; i < 3; i++) begin
            n2_ff[i]    <= pa1_ff[i] - pb1_ff[i];
            dp2_ff[i]   <= dp1_ff[i];
            v1sq2_ff[i] <= v1_1_ff[i] * v1_1_ff[i];
         end
         aa2_ff[0] <= dp1_ff[1] * v1_1_ff[2];
         ab2_ff[0] <= dp1_ff[2] * v1_1_ff[1];
         aa2_ff[1] <= dp1_ff[2] * v1_1_ff[0];
         ab2_ff[1] <= dp1_ff[0] * v1_1_ff[2];
         aa2_ff[2] <= dp1_ff[0] * v1_1_ff[1];
         ab2_ff[2] <= dp1_ff[1] * v1_1_ff[0];
         zero2_ff  <= (v1_1_ff[0] == '0) && (v1_1_ff[1] == '0) && (v1_1_ff[2] == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int i = 0; i < 3; i++) begin
            a3_ff[i]   <= aa2_ff[i] - ab2_ff[i];
            nsq3_ff[i] <= n2_ff[i] * n2_ff[i];
            pj3_ff[i]  <= dp2_ff[i] * n2_ff[i];
         end
         v1n3_ff  <= V2_W'(v1sq2_ff[0]) + V2_W'(v1sq2_ff[1]) + V2_W'(v1sq2_ff[2]);
         zero3_ff <= zero2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         for (int i = 0; i < 3; i++) begin
            asq4_ff[i] <= a3_ff[i] * a3_ff[i];
         end
         det4_ff  <= DET_W'(nsq3_ff[0]) + DET_W'(nsq3_ff[1]) + DET_W'(nsq3_ff[2]);
         proj4_ff <= PJ_W'(pj3_ff[0]) + PJ_W'(pj3_ff[1]) + PJ_W'(pj3_ff[2]);
         v1n4_ff  <= v1n3_ff;
         zero4_ff <= zero3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         mag5_ff  <= proj4_ff[PJ_W-1] ? $unsigned(-proj4_ff) : $unsigned(proj4_ff);
         skew5_ff <= det4_ff > DET_W'(threshold);
         a2_5_ff  <= A2_W'(asq4_ff[0]) + A2_W'(asq4_ff[1]) + A2_W'(asq4_ff[2]);
         det5_ff  <= det4_ff;
         v1n5_ff  <= v1n4_ff;
         zero5_ff <= zero4_ff;
      end
   end

   // partial products of the squared projection, and the status (skew before degenerate)
   always_ff @(posedge clock) begin
      if (en[6]) begin
         hh6_ff  <= mag5_ff[PJ_W-1:HALF_W] * mag5_ff[PJ_W-1:HALF_W];
         hl6_ff  <= mag5_ff[PJ_W-1:HALF_W] * mag5_ff[HALF_W-1:0];
         ll6_ff  <= mag5_ff[HALF_W-1:0] * mag5_ff[HALF_W-1:0];
         a2_6_ff <= a2_5_ff;
         det6_ff <= det5_ff;
         v1n6_ff <= v1n5_ff;
         if (skew5_ff) begin
            st6_ff <= STATUS_SKEW;
         end else if (zero5_ff) begin
            st6_ff <= STATUS_DEGENERATE;
         end else begin
            st6_ff <= STATUS_PARALLEL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         st7_ff <= st6_ff;
         unique case (st6_ff)
            STATUS_SKEW: begin
               num7_ff <= (NUM_W'(hh6_ff) << (2 * HALF_W)) + (NUM_W'(hl6_ff) << (HALF_W + 1))
                        + NUM_W'(ll6_ff);
               den7_ff <= det6_ff;
            end
            STATUS_PARALLEL: begin
               num7_ff <= NUM_W'(a2_6_ff);
               den7_ff <= DEN_W'(v1n6_ff);
            end
            default: begin
               num7_ff <= '0;
               den7_ff <= DEN_W'(1);
            end
         endcase
      end
   end

endmodule

// ===== design/lld_div.sv =====
// lld_div: restoring divider, one quotient bit per register stage, saturating quotient
// depends on lld_pkg
module lld_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  lld_pkg::div_in_type   in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output lld_pkg::root_in_type  out_data
);
   import lld_pkg::*;

   localparam int STAGES = QS_W;

   logic [STAGES-1:0] v_ff, v_in, en;
   logic [NUM_W-1:0]  rem_ff [STAGES];
   logic [DEN_W-1:0]  den_ff [STAGES];
   logic [QS_W-1:0]   q_ff [STAGES];
   status_type        st_ff [STAGES];

   always_comb begin
      v_in = {v_ff[STAGES-2:0], in_valid};
      en[STAGES-1] = !v_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[STAGES-1];

   // top quotient bit set means the ratio is at or above the saturation point
   assign out_data.q      = q_ff[STAGES-1][QW] ? '1 : q_ff[STAGES-1][QW-1:0];
   assign out_data.status = st_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (v_ff & ~en) | (v_in & en);
      end
   end

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic [NUM_W-1:0] rem_src, trial;
      logic [DEN_W-1:0] den_src;
      logic [QS_W-1:0]  q_src;
      status_type       st_src;

      if (k == 0) begin : g_first
         assign rem_src = in_data.num;
         assign den_src = in_data.den;
         assign q_src   = '0;
         assign st_src  = in_data.status;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign q_src   = q_ff[k-1];
         assign st_src  = st_ff[k-1];
      end

      assign trial = NUM_W'(den_src) << (QW - k);

      always_ff @(posedge clock) begin
         if (en[k]) begin
            den_ff[k] <= den_src;
            st_ff[k]  <= st_src;
            if (rem_src >= trial) begin
               rem_ff[k] <= rem_src - trial;
               q_ff[k]   <= q_src | (QS_W'(1) << (QW - k));
            end else begin
               rem_ff[k] <= rem_src;
               q_ff[k]   <= q_src;
            end
         end
      end
   end

endmodule

// ===== design/lld_root.sv =====
// lld_root: integer square root, one root bit per register stage, drives the result item
// depends on lld_pkg
module lld_root (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  lld_pkg::root_in_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output lld_pkg::rsp_type      out_data
);
   import lld_pkg::*;

   localparam int STAGES = DIST_W;

   logic [STAGES-1:0] v_ff, v_in, en;
   logic [QW-1:0]     rem_ff [STAGES];
   logic [DIST_W-1:0] root_ff [STAGES];
   status_type        st_ff [STAGES];

   always_comb begin
      v_in = {v_ff[STAGES-2:0], in_valid};
      en[STAGES-1] = !v_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[STAGES-1];
   assign out_data.distance = (st_ff[STAGES-1] == STATUS_DEGENERATE) ? '0 : root_ff[STAGES-1];
   assign out_data.status   = st_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (v_ff & ~en) | (v_in & en);
      end
   end

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      localparam int B = STAGES - 1 - k;
      logic [QW-1:0]     rem_src;
      logic [DIST_W-1:0] root_src;
      logic [QS_W-1:0]   trial;
      status_type        st_src;

      if (k == 0) begin : g_first
         assign rem_src  = in_data.q;
         assign root_src = '0;
         assign st_src   = in_data.status;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign st_src   = st_ff[k-1];
      end

      // (r + 2^b)^2 - r^2
      assign trial = (QS_W'(root_src) << (B + 1)) | (QS_W'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (en[k]) begin
            st_ff[k] <= st_src;
            if (QS_W'(rem_src) >= trial) begin
               rem_ff[k]  <= rem_src - trial[QW-1:0];
               root_ff[k] <= root_src | (DIST_W'(1) << B);
            end else begin
               rem_ff[k]  <= rem_src;
               root_ff[k] <= root_src;
            end
         end
      end
   end

endmodule

// ===== design/line_line_distance.sv =====
// line_line_distance: top level, threshold register and the three pipeline sections
// depends on lld_pkg, lld_geom, lld_div, lld_root
//
//   port group   direction   handshake           payload
//   req_         in          req_valid/ready     lld_pkg::req_type, two lines
//   rsp_         out         rsp_valid/ready     lld_pkg::rsp_type, distance and status
//   csr_         in          csr_write_enable    32-bit parallel threshold
//
// one item per cycle sustained while rsp_ready stays high, through the pipeline stages
// (7 geometry stages, 35 divider stages, 17 square root stages)
// synchronous reset clears the valid bits and the threshold
// each stage holds its item while the next is full and stalled; empty stages fill up
module line_line_distance (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [lld_pkg::CSR_W-1:0]  csr_write_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  lld_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output lld_pkg::rsp_type           rsp_data
);
   import lld_pkg::*;

   logic [CSR_W-1:0] thr_ff;
   logic             geom_valid, geom_ready, div_valid, div_ready;
   div_in_type       geom_data;
   root_in_type      div_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_write_enable) begin
         thr_ff <= csr_write_data;
      end
   end

   lld_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .threshold (thr_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (geom_valid),
      .out_ready (geom_ready),
      .out_data  (geom_data)
   );

   lld_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (geom_valid),
      .in_ready  (geom_ready),
      .in_data   (geom_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   lld_root u_root (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule
